FILE: hw/rtl/c2d_pkg.sv
// Shared constants, types and address helpers for the 2D convolution engine.
// Used by every module of the block; depends on nothing.
package c2d_pkg;

	// Store geometry
	localparam int MAX_IN_CHANNELS  = 64;
	localparam int MAX_OUT_CHANNELS = 32;
	localparam int MAX_ROWS         = 32;
	localparam int MAX_COLS         = 32;
	localparam int MAX_KERNEL       = 3;

	localparam int KTAPS        = MAX_KERNEL * MAX_KERNEL;
	localparam int WCHAN_STRIDE = MAX_IN_CHANNELS * KTAPS;
	localparam int SAMPLE_DEPTH = MAX_IN_CHANNELS * MAX_ROWS * MAX_COLS;
	localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * WCHAN_STRIDE;
	localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
	localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);

	// Data widths
	localparam int VAL_W  = 16;
	localparam int PROD_W = 32;
	localparam int ACC_W  = 48;

	// Command codes (carried on tuser)
	localparam logic [1:0] CMD_WR_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_WR_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_COMPUTE   = 2'd2;

	// Register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_IN_CH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OUT_CH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KSIZE  = 3'd4;
	localparam int CFG_W = 7;

	// Clamped configuration seen by the sequencer
	typedef struct packed {
		logic [6:0] nin;
		logic [5:0] nout;
		logic [5:0] h;
		logic [5:0] w;
		logic [1:0] k;
	} cfg_t;

	// Sequencer to MAC control
	typedef struct packed {
		logic clear;
		logic issue;
		logic tap_ok;
	} mac_ctl_t;

	// Offset of a tap inside one channel's kernel
	function automatic logic [3:0] tap_off(input logic [1:0] tr, input logic [1:0] tc);
		tap_off = 4'(tr) * 4'(MAX_KERNEL) + 4'(tc);
	endfunction

	// Weight store address: ((oc * IC + ic) * K + tr) * K + tc
	function automatic logic [WEIGHT_AW-1:0] weight_addr(input logic [4:0] oc,
		input logic [5:0] ic, input logic [1:0] tr, input logic [1:0] tc);
		logic [WEIGHT_AW-1:0] a;
		a = WEIGHT_AW'(oc) * WEIGHT_AW'(WCHAN_STRIDE);
		a = a + WEIGHT_AW'(ic) * WEIGHT_AW'(KTAPS);
		weight_addr = a + WEIGHT_AW'(tap_off(tr, tc));
	endfunction

	// Sample store address: (ic * ROWS + r) * COLS + c
	function automatic logic [SAMPLE_AW-1:0] sample_addr(input logic [5:0] ic,
		input logic [4:0] r, input logic [4:0] c);
		sample_addr = {ic, r, c};
	endfunction

endpackage

FILE: hw/rtl/c2d_mem.sv
// Sample and weight stores: one write port and one registered read port each.
// Depends on c2d_pkg.
module c2d_mem (
	input  logic                           clk,
	input  logic                           w_we,
	input  logic [c2d_pkg::WEIGHT_AW-1:0]  w_waddr,
	input  logic                           s_we,
	input  logic [c2d_pkg::SAMPLE_AW-1:0]  s_waddr,
	input  logic [c2d_pkg::VAL_W-1:0]      wdata,
	input  logic [c2d_pkg::WEIGHT_AW-1:0]  w_raddr,
	input  logic [c2d_pkg::SAMPLE_AW-1:0]  s_raddr,
	output logic [c2d_pkg::VAL_W-1:0]      w_rdata,
	output logic [c2d_pkg::VAL_W-1:0]      s_rdata
);

	logic [c2d_pkg::VAL_W-1:0] weight_mem [c2d_pkg::WEIGHT_DEPTH];
	logic [c2d_pkg::VAL_W-1:0] sample_mem [c2d_pkg::SAMPLE_DEPTH];

	// Weight store
	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_waddr] <= wdata;
		end
		w_rdata <= weight_mem[w_raddr];
	end

	// Sample store
	always_ff @(posedge clk) begin
		if (s_we) begin
			sample_mem[s_waddr] <= wdata;
		end
		s_rdata <= sample_mem[s_raddr];
	end

endmodule

FILE: hw/rtl/c2d_mac.sv
// Multiply-accumulate pipeline: store read data -> product register -> 48-bit sum.
// Depends on c2d_pkg.
module c2d_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  c2d_pkg::mac_ctl_t           ctl,
	input  logic [c2d_pkg::VAL_W-1:0]   w_rdata,
	input  logic [c2d_pkg::VAL_W-1:0]   s_rdata,
	output logic [c2d_pkg::ACC_W-1:0]   acc,
	output logic                        busy
);

	logic                               issue_s1;
	logic                               ok_s1;
	logic                               issue_s2;
	logic                               add_s2;
	logic signed [c2d_pkg::PROD_W-1:0]  prod_s2;
	logic signed [c2d_pkg::ACC_W-1:0]   acc_q;

	// Pipeline control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			ok_s1    <= 1'b0;
			issue_s2 <= 1'b0;
			add_s2   <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
			ok_s1    <= ctl.issue & ctl.tap_ok;
			issue_s2 <= issue_s1;
			add_s2   <= issue_s1 & ok_s1;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rdata) * $signed(s_rdata);
	end

	// Accumulator; taps off the image contribute nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (add_s2) begin
			acc_q <= acc_q + c2d_pkg::ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = issue_s1 | issue_s2;

endmodule

FILE: hw/rtl/c2d_seq.sv
// Compute sequencer: walks channels and kernel taps, drives store reads and MAC control.
// Depends on c2d_pkg.
module c2d_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  c2d_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	input  logic [1:0]                     in_cmd,
	input  logic [4:0]                     in_oc,
	input  logic [4:0]                     in_row,
	input  logic [4:0]                     in_col,
	input  logic                           out_free,
	input  logic                           mac_busy,
	output logic                           in_ready,
	output c2d_pkg::mac_ctl_t              ctl,
	output logic [c2d_pkg::WEIGHT_AW-1:0]  w_raddr,
	output logic [c2d_pkg::SAMPLE_AW-1:0]  s_raddr,
	output logic                           res_load,
	output logic [4:0]                     res_chan,
	output logic [4:0]                     res_row,
	output logic [4:0]                     res_col
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                     state_q;
	logic [4:0]                     oc_q;
	logic [4:0]                     row_q;
	logic [4:0]                     col_q;
	logic [5:0]                     c_q;
	logic [1:0]                     a_q;
	logic [1:0]                     b_q;
	logic [c2d_pkg::WEIGHT_AW-1:0]  chan_base_q;

	logic       start;
	logic       empty_sum;
	logic       half;
	logic [6:0] sr;
	logic [6:0] sc;
	logic       b_end;
	logic       a_end;
	logic       c_end;

	assign in_ready = (state_q == ST_IDLE);

	// Compute that yields a result
	assign start = in_ready && in_valid && (in_cmd == c2d_pkg::CMD_COMPUTE)
		&& (6'(in_oc) < cfg.nout) && (6'(in_row) < cfg.h) && (6'(in_col) < cfg.w);
	assign empty_sum = (cfg.nin == 7'd0) || (cfg.k == 2'd0);

	// Source position of the current tap
	assign half = cfg.k[1];
	assign sr = 7'(row_q) + 7'(half) - 7'(a_q);
	assign sc = 7'(col_q) + 7'(half) - 7'(b_q);

	assign b_end = (b_q == cfg.k - 2'd1);
	assign a_end = (a_q == cfg.k - 2'd1);
	assign c_end = ({1'b0, c_q} == cfg.nin - 7'd1);

	// Store reads and MAC control
	always_comb begin
		ctl.clear  = start;
		ctl.issue  = (state_q == ST_RUN);
		ctl.tap_ok = !sr[6] && (sr < 7'(cfg.h)) && !sc[6] && (sc < 7'(cfg.w));
		w_raddr    = chan_base_q + c2d_pkg::WEIGHT_AW'(c2d_pkg::tap_off(a_q, b_q));
		s_raddr    = c2d_pkg::sample_addr(c_q, sr[4:0], sc[4:0]);
	end

	assign res_load = (state_q == ST_DONE) && out_free;
	assign res_chan = oc_q;
	assign res_row  = row_q;
	assign res_col  = col_q;

	// Point coordinates of the running compute
	always_ff @(posedge clk) begin
		if (start) begin
			oc_q  <= in_oc;
			row_q <= in_row;
			col_q <= in_col;
		end
	end

	// State and tap counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			c_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			chan_base_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						c_q         <= '0;
						a_q         <= '0;
						b_q         <= '0;
						chan_base_q <= c2d_pkg::weight_addr(in_oc, 6'd0, 2'd0, 2'd0);
						state_q     <= empty_sum ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (b_end) begin
						b_q <= '0;
						if (a_end) begin
							a_q         <= '0;
							c_q         <= c_q + 6'd1;
							chan_base_q <= chan_base_q
								+ c2d_pkg::WEIGHT_AW'(c2d_pkg::KTAPS);
							if (c_end) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							a_q <= a_q + 2'd1;
						end
					end else begin
						b_q <= b_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/conv2d_same_pad_engine_top.sv
// Top level of the 2D convolution engine: stream ports, config registers, output register.
// Depends on c2d_pkg, c2d_mem, c2d_seq and c2d_mac.
//
// Usage: every input transaction carries a command on s_tuser. A weight or sample
// write is stored in the cycle it is accepted and gives no result. A compute
// transaction sums weight * sample over in_channels and all kernel taps (flipped
// kernel, zero padding, same output size) and returns one 48-bit Q32.16 result
// on the m_ side, tagged with channel, row and column. A compute outside the
// configured image or channel count, and an unused command, give no result.
// A compute runs one multiply-accumulate per cycle through a single read port on
// each store, N = nin * k * k of them, then waits in its drain state until the MAC
// pipeline is empty and hands the sum to the output register; m_tvalid and s_tready
// rise together when the result is loaded. No new transaction, not even a write,
// is taken while a compute runs.
// The output register holds a finished result while m_tready is low; further
// writes are still taken, and a following compute waits at its end until the
// register frees. Reset clears control state and restores the register
// defaults; the stores are not cleared and must be written before use.
// Config writes must be made only while the block is idle.
module conv2d_same_pad_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [c2d_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [c2d_pkg::CFG_W-1:0]         cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// out_chan[4:0] in_chan[10:5] row[15:11] col[20:16] tap_row[22:21]
	// tap_col[24:23] value[40:25], zero fill above
	input  logic [47:0]                       s_tdata,
	// cmd[1:0]
	input  logic [1:0]                        s_tuser,
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_value[47:0] res_chan[52:48] res_row[57:53] res_col[62:58], zero fill above
	output logic [63:0]                       m_tdata
);

	logic [6:0] in_ch_q;
	logic [5:0] out_ch_q;
	logic [5:0] height_q;
	logic [5:0] width_q;
	logic [1:0] ksize_q;

	c2d_pkg::cfg_t     cfg;
	c2d_pkg::mac_ctl_t ctl;

	logic [4:0]  f_oc;
	logic [5:0]  f_ic;
	logic [4:0]  f_row;
	logic [4:0]  f_col;
	logic [1:0]  f_tr;
	logic [1:0]  f_tc;
	logic [15:0] f_value;

	logic                            accept;
	logic                            w_we;
	logic                            s_we;
	logic [c2d_pkg::WEIGHT_AW-1:0]   w_raddr;
	logic [c2d_pkg::SAMPLE_AW-1:0]   s_raddr;
	logic [c2d_pkg::VAL_W-1:0]       w_rdata;
	logic [c2d_pkg::VAL_W-1:0]       s_rdata;
	logic [c2d_pkg::ACC_W-1:0]       acc;
	logic                            mac_busy;
	logic                            out_free;
	logic                            res_load;
	logic [4:0]                      res_chan;
	logic [4:0]                      res_row;
	logic [4:0]                      res_col;
	logic                            m_tvalid_q;
	logic [63:0]                     m_tdata_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 7'd1;
			out_ch_q <= 6'd1;
			height_q <= 6'd32;
			width_q  <= 6'd32;
			ksize_q  <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				c2d_pkg::REG_IN_CH:  in_ch_q  <= cfg_wdata;
				c2d_pkg::REG_OUT_CH: out_ch_q <= cfg_wdata[5:0];
				c2d_pkg::REG_HEIGHT: height_q <= cfg_wdata[5:0];
				c2d_pkg::REG_WIDTH:  width_q  <= cfg_wdata[5:0];
				c2d_pkg::REG_KSIZE:  ksize_q  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Clamp registers to the store limits
	always_comb begin
		cfg.nin  = (in_ch_q > 7'(c2d_pkg::MAX_IN_CHANNELS))
			? 7'(c2d_pkg::MAX_IN_CHANNELS) : in_ch_q;
		cfg.nout = (out_ch_q > 6'(c2d_pkg::MAX_OUT_CHANNELS))
			? 6'(c2d_pkg::MAX_OUT_CHANNELS) : out_ch_q;
		cfg.h    = (height_q > 6'(c2d_pkg::MAX_ROWS)) ? 6'(c2d_pkg::MAX_ROWS) : height_q;
		cfg.w    = (width_q > 6'(c2d_pkg::MAX_COLS)) ? 6'(c2d_pkg::MAX_COLS) : width_q;
		cfg.k    = (ksize_q > 2'(c2d_pkg::MAX_KERNEL)) ? 2'(c2d_pkg::MAX_KERNEL) : ksize_q;
	end

	// Input field unpack
	assign f_oc    = s_tdata[4:0];
	assign f_ic    = s_tdata[10:5];
	assign f_row   = s_tdata[15:11];
	assign f_col   = s_tdata[20:16];
	assign f_tr    = s_tdata[22:21];
	assign f_tc    = s_tdata[24:23];
	assign f_value = s_tdata[40:25];

	// Store writes; weight taps beyond the kernel store are dropped
	assign accept = s_tvalid && s_tready;
	assign w_we   = accept && (s_tuser == c2d_pkg::CMD_WR_WEIGHT)
		&& (f_tr < 2'(c2d_pkg::MAX_KERNEL)) && (f_tc < 2'(c2d_pkg::MAX_KERNEL));
	assign s_we   = accept && (s_tuser == c2d_pkg::CMD_WR_SAMPLE);

	c2d_mem u_mem (
		.clk     (clk),
		.w_we    (w_we),
		.w_waddr (c2d_pkg::weight_addr(f_oc, f_ic, f_tr, f_tc)),
		.s_we    (s_we),
		.s_waddr (c2d_pkg::sample_addr(f_ic, f_row, f_col)),
		.wdata   (f_value),
		.w_raddr (w_raddr),
		.s_raddr (s_raddr),
		.w_rdata (w_rdata),
		.s_rdata (s_rdata)
	);

	c2d_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_oc    (f_oc),
		.in_row   (f_row),
		.in_col   (f_col),
		.out_free (out_free),
		.mac_busy (mac_busy),
		.in_ready (s_tready),
		.ctl      (ctl),
		.w_raddr  (w_raddr),
		.s_raddr  (s_raddr),
		.res_load (res_load),
		.res_chan (res_chan),
		.res_row  (res_row),
		.res_col  (res_col)
	);

	c2d_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.w_rdata (w_rdata),
		.s_rdata (s_rdata),
		.acc     (acc),
		.busy    (mac_busy)
	);

	// Output register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_tdata_q <= {1'b0, res_col, res_row, res_chan, acc};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hw/rtl/c2d_checker.sv
// Port-level assertions for the convolution engine, bound to the top level.
// Depends on c2d_pkg and conv2d_same_pad_engine_top.
module c2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// Stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// Stalled result keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// A store write never produces a result on its own
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != c2d_pkg::CMD_COMPUTE) |=> !$rose(m_tvalid))
		else $error("result appeared after a write transaction");

	// A result is only loaded while the input side is blocked by a running compute
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared with no compute in flight");

endmodule

bind conv2d_same_pad_engine_top c2d_checker u_c2d_checker (.*);

FILE: verif/conv2d_same_pad_engine_checker.sv
// Checker for the 2D convolution engine: watches config writes and both stream channels,
// keeps its own weight/sample stores and register copy, predicts each output point, compares.
// Depends on c2d_pkg for register indexes, command codes and store geometry.
`timescale 1ns / 100ps

module conv2d_same_pad_engine_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [c2d_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [c2d_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// out_chan[4:0] in_chan[10:5] row[15:11] col[20:16] tap_row[22:21]
	// tap_col[24:23] value[40:25], zero fill above
	input  logic [47:0]                   s_tdata,
	// cmd[1:0]
	input  logic [1:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// out_value[47:0] res_chan[52:48] res_row[57:53] res_col[62:58], zero fill above
	input  logic [63:0]                   m_tdata,
	output int                            mismatch_count,
	output int                            points_pending
);
	import c2d_pkg::*;

	// Packed so that the low bits line up with m_tdata
	typedef struct packed {
		logic [4:0]  col;
		logic [4:0]  row;
		logic [4:0]  chan;
		logic [47:0] acc_val;
	} point_t;

	logic [VAL_W-1:0] sample_mem [MAX_IN_CHANNELS][MAX_ROWS][MAX_COLS];
	logic [VAL_W-1:0] weight_mem [MAX_OUT_CHANNELS][MAX_IN_CHANNELS][MAX_KERNEL][MAX_KERNEL];

	// register copy, raw as written
	logic [6:0] in_ch;
	logic [5:0] out_ch;
	logic [5:0] img_h;
	logic [5:0] img_w;
	logic [1:0] ksz;

	point_t pending_points [$];
	int     err_cnt = 0;

	assign mismatch_count = err_cnt;

	function automatic int clip(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	// Flipped-kernel sum for one output point, padding reads as zero
	function automatic logic [47:0] conv_point(input logic [4:0] oc, input logic [4:0] row,
		input logic [4:0] col);
		int     nin, k, h, w, half, sr, sc;
		longint acc;
		nin  = clip(int'(in_ch), MAX_IN_CHANNELS);
		k    = clip(int'(ksz), MAX_KERNEL);
		h    = clip(int'(img_h), MAX_ROWS);
		w    = clip(int'(img_w), MAX_COLS);
		half = k / 2;
		acc  = 0;
		for (int c = 0; c < nin; c++) begin
			for (int a = 0; a < k; a++) begin
				sr = int'(row) + half - a;
				if (sr < 0 || sr >= h)
					continue;
				for (int b = 0; b < k; b++) begin
					sc = int'(col) + half - b;
					if (sc < 0 || sc >= w)
						continue;
					acc += longint'($signed(weight_mem[oc][c][a][b])) *
						longint'($signed(sample_mem[c][sr][sc]));
				end
			end
		end
		return acc[47:0];
	endfunction

	task automatic report_field(input string name, input logic [47:0] want_v,
		input logic [47:0] got_v);
		err_cnt++;
		$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
	endtask

	// Track writes, predict computes, compare results in order
	always @(posedge clk or negedge arst_n) begin : track
		point_t      got, want, pred;
		logic [4:0]  oc, row, col;
		logic [5:0]  ic;
		logic [1:0]  tr, tc;
		logic [15:0] val;
		if (!arst_n) begin
			in_ch  = 7'd1;
			out_ch = 6'd1;
			img_h  = 6'd32;
			img_w  = 6'd32;
			ksz    = 2'd3;
			pending_points.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_IN_CH:  in_ch  = cfg_wdata[6:0];
					REG_OUT_CH: out_ch = cfg_wdata[5:0];
					REG_HEIGHT: img_h  = cfg_wdata[5:0];
					REG_WIDTH:  img_w  = cfg_wdata[5:0];
					REG_KSIZE:  ksz    = cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				oc  = s_tdata[4:0];
				ic  = s_tdata[10:5];
				row = s_tdata[15:11];
				col = s_tdata[20:16];
				tr  = s_tdata[22:21];
				tc  = s_tdata[24:23];
				val = s_tdata[40:25];
				case (s_tuser)
					CMD_WR_WEIGHT: begin
						if (tr < MAX_KERNEL && tc < MAX_KERNEL)
							weight_mem[oc][ic][tr][tc] = val;
					end
					CMD_WR_SAMPLE: sample_mem[ic][row][col] = val;
					CMD_COMPUTE: begin
						if (oc < clip(int'(out_ch), MAX_OUT_CHANNELS) &&
							row < clip(int'(img_h), MAX_ROWS) &&
							col < clip(int'(img_w), MAX_COLS)) begin
							pred.col     = col;
							pred.row     = row;
							pred.chan    = oc;
							pred.acc_val = conv_point(oc, row, col);
							pending_points = {pending_points, pred};
						end
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = point_t'(m_tdata[62:0]);
				if (pending_points.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				end else begin
					want = pending_points.pop_front();
					if (got.acc_val !== want.acc_val)
						report_field("out_value", want.acc_val, got.acc_val);
					if (got.chan !== want.chan)
						report_field("res_chan", 48'(want.chan), 48'(got.chan));
					if (got.row !== want.row)
						report_field("res_row", 48'(want.row), 48'(got.row));
					if (got.col !== want.col)
						report_field("res_col", 48'(want.col), 48'(got.col));
				end
			end
		end
		points_pending = pending_points.size();
	end

endmodule

FILE: verif/conv2d_same_pad_engine_top_tb.sv
// Testbench top for the 2D convolution engine: clock, reset, config phases, stream stimulus
// with random gaps and back-pressure, watchdog and verdict.
// Depends on c2d_pkg, conv2d_same_pad_engine_top and conv2d_same_pad_engine_checker.
`timescale 1ns / 100ps

module conv2d_same_pad_engine_top_tb;
	import c2d_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int ITEM_TARGET    = 1040;
	localparam int MAX_GAP        = 13;
	localparam int DRAIN_CYCLES   = 600;   // one full 64-channel 3x3 compute plus drain
	localparam int LONG_HOLD      = 3000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [47:0]          s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [63:0]          m_tdata;
	int                   mismatch_count;
	int                   points_pending;

	// entries already written, so that no compute reads an undefined entry
	bit weight_seen [MAX_OUT_CHANNELS][MAX_IN_CHANNELS][MAX_KERNEL][MAX_KERNEL];
	bit sample_seen [MAX_IN_CHANNELS][MAX_ROWS][MAX_COLS];

	// effective (clamped) configuration currently programmed
	int cur_nin, cur_nout, cur_h, cur_w, cur_k;

	int items_sent;
	int quiet_cycles;
	int tx_run_left;
	bit tx_fast;
	bit hold_req;
	bit hold_taken;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	conv2d_same_pad_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	conv2d_same_pad_engine_checker conv_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatch_count(mismatch_count),
		.points_pending(points_pending)
	);

	function automatic logic [47:0] pack_item(input int oc, input int ic, input int row,
		input int col, input int tr, input int tc, input logic [15:0] val);
		return {7'd0, val, 2'(tc), 2'(tr), 5'(col), 5'(row), 6'(ic), 5'(oc)};
	endfunction

	// biased toward the Q8.8 extremes
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// index inside the range in use, or anywhere when that range is empty
	function automatic int pick_below(input int n, input int full);
		return (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, full - 1);
	endfunction

	function automatic int clamp(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	// Config write; called at a falling edge while the block is idle
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
		cfg_addr  = idx;
		cfg_wdata = CFG_W'(val);
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_config(input int nin, input int nout, input int h, input int w,
		input int k);
		write_reg(REG_IN_CH, nin);
		write_reg(REG_OUT_CH, nout);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_KSIZE, k);
		cur_nin  = clamp(nin & 8'h7F, MAX_IN_CHANNELS);
		cur_nout = clamp(nout & 8'h3F, MAX_OUT_CHANNELS);
		cur_h    = clamp(h & 8'h3F, MAX_ROWS);
		cur_w    = clamp(w & 8'h3F, MAX_COLS);
		cur_k    = clamp(k & 8'h3, MAX_KERNEL);
	endtask

	// One input transaction with a random lead-in gap; returns at the falling edge
	// after acceptance, tvalid still high so back-to-back items need no toggle
	task automatic send_txn(input logic [1:0] cmd, input logic [47:0] data, input bit counted);
		int gap;
		if (tx_run_left == 0) begin
			tx_fast     = ($urandom_range(0, 3) == 0);
			tx_run_left = $urandom_range(10, 40);
		end
		tx_run_left--;
		gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = cmd;
		s_tdata  = data;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (counted)
			items_sent++;
	endtask

	task automatic put_weight(input int oc, input int ic, input int tr, input int tc,
		input logic [15:0] val);
		bit stored;
		stored = (tr < MAX_KERNEL && tc < MAX_KERNEL);
		if (stored)
			weight_seen[oc][ic][tr][tc] = 1'b1;
		send_txn(CMD_WR_WEIGHT, pack_item(oc, ic, $urandom_range(0, 31), $urandom_range(0, 31),
			tr, tc, val), stored);
	endtask

	task automatic put_sample(input int ic, input int row, input int col,
		input logic [15:0] val);
		sample_seen[ic][row][col] = 1'b1;
		send_txn(CMD_WR_SAMPLE, pack_item($urandom_range(0, 31), ic, row, col,
			$urandom_range(0, 3), $urandom_range(0, 3), val), 1'b1);
	endtask

	// Compute request; first writes any entry the point will read that is still undefined
	task automatic ask_point(input int oc, input int row, input int col);
		int half, sr, sc;
		if (oc < cur_nout && row < cur_h && col < cur_w) begin
			half = cur_k / 2;
			for (int c = 0; c < cur_nin; c++) begin
				for (int a = 0; a < cur_k; a++) begin
					sr = row + half - a;
					if (sr < 0 || sr >= cur_h)
						continue;
					for (int b = 0; b < cur_k; b++) begin
						sc = col + half - b;
						if (sc < 0 || sc >= cur_w)
							continue;
						if (!weight_seen[oc][c][a][b])
							put_weight(oc, c, a, b, pick_value());
						if (!sample_seen[c][sr][sc])
							put_sample(c, sr, sc, pick_value());
					end
				end
			end
		end
		send_txn(CMD_COMPUTE, pack_item(oc, $urandom_range(0, 63), row, col,
			$urandom_range(0, 3), $urandom_range(0, 3), 16'($urandom)), 1'b1);
	endtask

	// Sender stops until every result is back, then lets a silent compute finish
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (points_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mixed traffic: mostly in-range computes and writes, some out-of-range and unused items;
	// stops early once the item budget is spent
	task automatic run_phase(input int nitems);
		int sel;
		for (int i = 0; i < nitems && items_sent < ITEM_TARGET; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				ask_point(pick_below(cur_nout, 32), pick_below(cur_h, 32), pick_below(cur_w, 32));
			else if (sel < 45)
				ask_point($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
			else if (sel < 70) begin
				if ($urandom_range(0, 4) == 0)
					put_sample($urandom_range(0, 63), $urandom_range(0, 31),
						$urandom_range(0, 31), pick_value());
				else
					put_sample(pick_below(cur_nin, 64), pick_below(cur_h, 32),
						pick_below(cur_w, 32), pick_value());
			end else if (sel < 95) begin
				if ($urandom_range(0, 4) == 0)
					put_weight($urandom_range(0, 31), $urandom_range(0, 63),
						$urandom_range(0, 3), $urandom_range(0, 3), pick_value());
				else
					put_weight(pick_below(cur_nout, 32), pick_below(cur_nin, 64),
						pick_below(cur_k, 3), pick_below(cur_k, 3), pick_value());
			end else
				send_txn(CMD_UNUSED, {7'd0, 41'({$urandom, $urandom})}, 1'b0);
		end
		wait_idle();
	endtask

	// Result side: random stalls, fast stretches, one long hold on request
	initial begin : result_side
		int gap, run_left;
		bit fast;
		m_tready = 1'b0;
		run_left = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready   = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (run_left == 0) begin
				fast     = ($urandom_range(0, 3) == 0);
				run_left = $urandom_range(10, 40);
			end
			run_left--;
			gap = fast ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("conv2d_same_pad_engine_top_tb NOT OK");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		int kind, n_items, v_nin, v_nout, v_h, v_w, v_k;
		logic [15:0] corner_w;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_addr    = '0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		items_sent  = 0;
		tx_run_left = 0;
		hold_req    = 1'b0;
		hold_taken  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: 2x2 image, 3x3 kernel, all four corners see padding;
		// most taps and samples at -1.0 * 128 to hit the largest products
		set_config(1, 1, 2, 2, 3);
		for (int i = 0; i < 9; i++) begin
			corner_w = (i % 2 == 0) ? 16'h8000 : (i == 1) ? 16'h7FFF :
				(i == 3) ? 16'hFFFF : (i == 5) ? 16'h0001 : 16'h0000;
			put_weight(0, 0, i / 3, i % 3, corner_w);
		end
		put_sample(0, 0, 0, 16'h8000);
		put_sample(0, 0, 1, 16'h7FFF);
		put_sample(0, 1, 0, 16'h8000);
		put_sample(0, 1, 1, 16'h8000);
		ask_point(0, 0, 0);
		ask_point(0, 0, 1);
		ask_point(0, 1, 0);
		ask_point(0, 1, 1);
		// unused command, tap beyond the kernel, far corners of both stores
		send_txn(CMD_UNUSED, pack_item(31, 63, 31, 31, 3, 3, 16'hFFFF), 1'b0);
		put_weight(0, 0, 3, 1, 16'h1234);
		put_weight(31, 63, 2, 2, 16'h7FFF);
		put_sample(63, 31, 31, 16'h8000);
		// computes outside the image and outside the channel count
		ask_point(0, 2, 0);
		ask_point(1, 0, 0);
		wait_idle();

		// Register extremes, clamping and degenerate settings
		set_config(127, 1, 1, 1, 3);
		run_phase(12);
		set_config(1, 63, 63, 63, 3);
		run_phase(24);
		set_config(64, 2, 2, 2, 1);
		run_phase(16);
		set_config(0, 4, 4, 4, 3);
		run_phase(12);
		set_config(3, 4, 4, 4, 0);
		run_phase(12);
		set_config(2, 0, 0, 0, 3);
		run_phase(12);
		set_config(3, 3, 5, 5, 2);
		run_phase(30);

		// Random phases; the first one runs under a long result-side hold
		hold_req = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			kind   = hold_taken ? $urandom_range(0, 9) : 0;
			v_nin  = $urandom_range(1, 4);
			v_nout = $urandom_range(1, 4);
			v_h    = $urandom_range(1, 6);
			v_w    = $urandom_range(1, 6);
			v_k    = ($urandom_range(0, 3) == 0) ? 1 : 3;
			n_items = 40;
			case (kind)
				6: begin
					v_nin   = $urandom_range(60, 127);
					v_nout  = $urandom_range(1, 2);
					v_h     = 1;
					v_w     = 1;
					n_items = 20;
				end
				7: begin
					v_nin   = $urandom_range(1, 2);
					v_nout  = $urandom_range(17, 63);
					v_h     = $urandom_range(28, 63);
					v_w     = $urandom_range(28, 63);
					v_k     = 3;
					n_items = 20;
				end
				8: begin
					case ($urandom_range(0, 4))
						0: v_nin  = 0;
						1: v_nout = 0;
						2: v_h    = 0;
						3: v_w    = 0;
						default: v_k = 0;
					endcase
					n_items = 20;
				end
				9: begin
					v_k     = 2;
					n_items = 30;
				end
				default: ;
			endcase
			set_config(v_nin, v_nout, v_h, v_w, v_k);
			run_phase(n_items);
		end

		wait_idle();
		if (mismatch_count == 0 && points_pending == 0)
			$display("conv2d_same_pad_engine_top_tb OK");
		else
			$display("conv2d_same_pad_engine_top_tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/c2d_pkg.sv
hw/rtl/c2d_mem.sv
hw/rtl/c2d_mac.sv
hw/rtl/c2d_seq.sv
hw/rtl/conv2d_same_pad_engine_top.sv
hw/rtl/c2d_checker.sv
verif/conv2d_same_pad_engine_checker.sv
verif/conv2d_same_pad_engine_top_tb.sv
